// ===== hdl/pcf_pkg.sv =====
// pcf_pkg: shared types, codes and frame constants for the pump command framer
// no dependencies; used by every other file of the block
`timescale 1ns / 1ps
`default_nettype none

package pcf_pkg;

   localparam int CMD_W      = 4;
   localparam int ADDR_W     = 4;
   localparam int VAL_W      = 16;
   localparam int BYTE_W     = 8;
   localparam int POS_W      = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int IDX_W      = 3;
   localparam int BCD_DIGITS = 5;
   localparam int BCD_W      = 4 * BCD_DIGITS;

   // only the low VALUE_WIDTH bits of the value field take part
   localparam int VALUE_WIDTH = 16;
   localparam logic [VAL_W-1:0] VALUE_MASK = (VALUE_WIDTH >= VAL_W) ? {VAL_W{1'b1}} :
      VAL_W'((64'd1 << VALUE_WIDTH) - 64'd1);

   localparam int CONV_STEPS = VAL_W;
   localparam int CONV_CNT_W = $clog2(CONV_STEPS);

   localparam logic [CSR_IDX_W-1:0] CSR_LOWER_LIMIT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER_LIMIT = 1'b1;

   localparam logic [CMD_W-1:0] CMD_T     = 4'd0;
   localparam logic [CMD_W-1:0] CMD_I     = 4'd1;
   localparam logic [CMD_W-1:0] CMD_O     = 4'd2;
   localparam logic [CMD_W-1:0] CMD_A     = 4'd3;
   localparam logic [CMD_W-1:0] CMD_D     = 4'd4;
   localparam logic [CMD_W-1:0] CMD_P     = 4'd5;
   localparam logic [CMD_W-1:0] CMD_Y20   = 4'd6;
   localparam logic [CMD_W-1:0] CMD_S     = 4'd7;
   localparam logic [CMD_W-1:0] CMD_Y20IS = 4'd8;
   localparam logic [CMD_W-1:0] CMD_Q     = 4'd9;

   localparam logic [BYTE_W-1:0] STX_BYTE   = 8'h02;
   localparam logic [BYTE_W-1:0] ETX_BYTE   = 8'h03;
   localparam logic [BYTE_W-1:0] SEQ_BYTE   = 8'h31;
   localparam logic [BYTE_W-1:0] ADDR_BASE  = 8'h31;
   localparam logic [BYTE_W-1:0] DIGIT_BASE = 8'h30;
   localparam logic [BYTE_W-1:0] EXEC_BYTE  = 8'h52;

   localparam logic [BYTE_W-1:0] CH_T    = 8'h54;
   localparam logic [BYTE_W-1:0] CH_I    = 8'h49;
   localparam logic [BYTE_W-1:0] CH_O    = 8'h4F;
   localparam logic [BYTE_W-1:0] CH_A    = 8'h41;
   localparam logic [BYTE_W-1:0] CH_D    = 8'h44;
   localparam logic [BYTE_W-1:0] CH_P    = 8'h50;
   localparam logic [BYTE_W-1:0] CH_Y    = 8'h59;
   localparam logic [BYTE_W-1:0] CH_S    = 8'h53;
   localparam logic [BYTE_W-1:0] CH_Q    = 8'h51;
   localparam logic [BYTE_W-1:0] CH_TWO  = 8'h32;
   localparam logic [BYTE_W-1:0] CH_ZERO = 8'h30;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_HEAD,
      ST_LETTER,
      ST_DIGIT,
      ST_TAIL
   } state_type;

   typedef enum logic [2:0] {
      SEL_STX,
      SEL_ADDR,
      SEL_SEQ,
      SEL_LETTER,
      SEL_DIGIT,
      SEL_EXEC,
      SEL_ETX,
      SEL_SUM
   } byte_sel_type;

   typedef struct packed {
      logic             load;
      logic             conv_step;
      logic             emit;
      byte_sel_type     sel;
      logic [IDX_W-1:0] idx;
      logic             last;
   } ctl_type;

   typedef struct packed {
      logic             frame_go;
      logic             has_value;
      logic             value_kind;
      logic             out_free;
      logic [IDX_W-1:0] letter_last;
      logic [IDX_W-1:0] top_digit;
   } sts_type;

   function automatic logic cmd_known(input logic [CMD_W-1:0] cmd);
      return cmd <= CMD_Q;
   endfunction

   function automatic logic cmd_has_value(input logic [CMD_W-1:0] cmd);
      return (cmd == CMD_A) || (cmd == CMD_D) || (cmd == CMD_P) ||
             (cmd == CMD_S) || (cmd == CMD_Y20IS);
   endfunction

   function automatic logic [IDX_W-1:0] letter_last(input logic [CMD_W-1:0] cmd);
      logic [IDX_W-1:0] res;
      res = 3'd0;
      if (cmd == CMD_Y20) begin
         res = 3'd2;
      end else if (cmd == CMD_Y20IS) begin
         res = 3'd4;
      end
      return res;
   endfunction

   function automatic logic [BYTE_W-1:0] letter_byte(input logic [CMD_W-1:0] cmd,
                                                     input logic [IDX_W-1:0] idx);
      logic [BYTE_W-1:0] res;
      res = CH_Q;
      unique case (cmd)
         CMD_T: res = CH_T;
         CMD_I: res = CH_I;
         CMD_O: res = CH_O;
         CMD_A: res = CH_A;
         CMD_D: res = CH_D;
         CMD_P: res = CH_P;
         CMD_S: res = CH_S;
         CMD_Y20, CMD_Y20IS: begin
            unique case (idx)
               3'd0: res = CH_Y;
               3'd1: res = CH_TWO;
               3'd2: res = CH_ZERO;
               3'd3: res = CH_I;
               3'd4: res = CH_S;
               default: res = CH_Y;
            endcase
         end
         default: res = CH_Q;
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/pcf_if.sv =====
// pcf_req_if and pcf_rsp_if: valid/ready channels of the pump command framer
// depends on pcf_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface pcf_req_if;
   logic                         valid;
   logic                         ready;
   logic [pcf_pkg::CMD_W-1:0]    cmd;
   logic [pcf_pkg::ADDR_W-1:0]   pump_address;
   logic [pcf_pkg::VAL_W-1:0]    value;

   modport source (output valid, output cmd, output pump_address, output value,
                   input ready);
   modport sink   (input valid, input cmd, input pump_address, input value,
                   output ready);
endinterface

interface pcf_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [pcf_pkg::BYTE_W-1:0]   tx_byte;
   logic                         last_byte;

   modport source (output valid, output tx_byte, output last_byte, input ready);
   modport sink   (input valid, input tx_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// ===== hdl/pcf_ctrl.sv =====
// pcf_ctrl: frame sequencer state machine of the pump command framer
// depends on pcf_pkg; drives pcf_datapath through ctl_type, reads sts_type
`timescale 1ns / 1ps
`default_nettype none

module pcf_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire pcf_pkg::sts_type  sts,
   output pcf_pkg::ctl_type       ctl
);

   pcf_pkg::state_type                 state_ff, state_in;
   logic [pcf_pkg::IDX_W-1:0]          cnt_ff, cnt_in;
   logic [pcf_pkg::CONV_CNT_W-1:0]     conv_ff, conv_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pcf_pkg::ST_IDLE;
         cnt_ff   <= '0;
         conv_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         conv_ff  <= conv_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      conv_in       = conv_ff;
      req_ready     = 1'b0;
      ctl.load      = 1'b0;
      ctl.conv_step = 1'b0;
      ctl.emit      = 1'b0;
      ctl.sel       = pcf_pkg::SEL_STX;
      ctl.idx       = cnt_ff;
      ctl.last      = 1'b0;
      unique case (state_ff)
         pcf_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            ctl.load  = req_valid;
            if (req_valid && sts.frame_go) begin
               cnt_in   = '0;
               conv_in  = '0;
               state_in = sts.has_value ? pcf_pkg::ST_CONV : pcf_pkg::ST_HEAD;
            end
         end
         pcf_pkg::ST_CONV: begin
            ctl.conv_step = 1'b1;
            conv_in       = conv_ff + 1'b1;
            if (conv_ff == pcf_pkg::CONV_CNT_W'(pcf_pkg::CONV_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = pcf_pkg::ST_HEAD;
            end
         end
         pcf_pkg::ST_HEAD: begin
            unique case (cnt_ff)
               3'd0:    ctl.sel = pcf_pkg::SEL_STX;
               3'd1:    ctl.sel = pcf_pkg::SEL_ADDR;
               default: ctl.sel = pcf_pkg::SEL_SEQ;
            endcase
            ctl.emit = sts.out_free;
            if (sts.out_free) begin
               if (cnt_ff == 3'd2) begin
                  cnt_in   = '0;
                  state_in = pcf_pkg::ST_LETTER;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         pcf_pkg::ST_LETTER: begin
            ctl.sel  = pcf_pkg::SEL_LETTER;
            ctl.emit = sts.out_free;
            if (sts.out_free) begin
               if (cnt_ff == sts.letter_last) begin
                  if (sts.value_kind) begin
                     cnt_in   = sts.top_digit;
                     state_in = pcf_pkg::ST_DIGIT;
                  end else begin
                     cnt_in   = '0;
                     state_in = pcf_pkg::ST_TAIL;
                  end
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         pcf_pkg::ST_DIGIT: begin
            ctl.sel  = pcf_pkg::SEL_DIGIT;
            ctl.emit = sts.out_free;
            if (sts.out_free) begin
               if (cnt_ff == '0) begin
                  state_in = pcf_pkg::ST_TAIL;
               end else begin
                  cnt_in = cnt_ff - 1'b1;
               end
            end
         end
         pcf_pkg::ST_TAIL: begin
            unique case (cnt_ff)
               3'd0:    ctl.sel = pcf_pkg::SEL_EXEC;
               3'd1:    ctl.sel = pcf_pkg::SEL_ETX;
               default: ctl.sel = pcf_pkg::SEL_SUM;
            endcase
            ctl.last = (cnt_ff == 3'd2);
            ctl.emit = sts.out_free;
            if (sts.out_free) begin
               if (cnt_ff == 3'd2) begin
                  cnt_in   = '0;
                  state_in = pcf_pkg::ST_IDLE;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = pcf_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hdl/pcf_datapath.sv =====
// pcf_datapath: limit registers, tracked position, decimal converter,
// byte selection, checksum and output register; depends on pcf_pkg
`timescale 1ns / 1ps
`default_nettype none

module pcf_datapath (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_wr_en,
   input  wire logic [pcf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [pcf_pkg::POS_W-1:0]          csr_wdata,
   input  wire logic [pcf_pkg::CMD_W-1:0]          req_cmd,
   input  wire logic [pcf_pkg::ADDR_W-1:0]         req_pump_address,
   input  wire logic [pcf_pkg::VAL_W-1:0]          req_value,
   input  wire logic                               rsp_ready,
   output logic                                    rsp_valid,
   output logic [pcf_pkg::BYTE_W-1:0]              rsp_tx_byte,
   output logic                                    rsp_last_byte,
   input  wire pcf_pkg::ctl_type                   ctl,
   output pcf_pkg::sts_type                        sts
);

   logic [pcf_pkg::POS_W-1:0]   lower_ff, lower_in;
   logic [pcf_pkg::POS_W-1:0]   upper_ff, upper_in;
   logic [pcf_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic [pcf_pkg::CMD_W-1:0]   cmd_ff, cmd_in;
   logic [pcf_pkg::ADDR_W-1:0]  addr_ff, addr_in;
   logic [pcf_pkg::VAL_W-1:0]   shift_ff, shift_in;
   logic [pcf_pkg::BCD_W-1:0]   bcd_ff, bcd_in;
   logic [pcf_pkg::BYTE_W-1:0]  sum_ff, sum_in;
   logic                        out_valid_ff, out_valid_in;
   logic [pcf_pkg::BYTE_W-1:0]  out_byte_ff, out_byte_in;
   logic                        out_last_ff, out_last_in;

   logic [pcf_pkg::VAL_W-1:0]   val_masked;
   logic [pcf_pkg::POS_W:0]     up_bound;
   logic [pcf_pkg::POS_W:0]     down_sum;
   logic                        refused;
   logic                        frame_go;
   logic [pcf_pkg::IDX_W-1:0]   top_digit;
   logic [pcf_pkg::BCD_W-1:0]   bcd_adj;
   logic [3:0]                  digit;
   logic [pcf_pkg::BYTE_W-1:0]  byte_sel;

   always_ff @(posedge clock) begin
      if (reset) begin
         lower_ff     <= '0;
         upper_ff     <= '1;
         pos_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         lower_ff     <= lower_in;
         upper_ff     <= upper_in;
         pos_ff       <= pos_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      addr_ff     <= addr_in;
      shift_ff    <= shift_in;
      bcd_ff      <= bcd_in;
      sum_ff      <= sum_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   // limit registers
   always_comb begin
      lower_in = lower_ff;
      upper_in = upper_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            pcf_pkg::CSR_LOWER_LIMIT: lower_in = csr_wdata;
            pcf_pkg::CSR_UPPER_LIMIT: upper_in = csr_wdata;
            default: lower_in = lower_ff;
         endcase
      end
   end

   // move checks against the limits
   always_comb begin
      val_masked = req_value & pcf_pkg::VALUE_MASK;
      up_bound   = {1'b0, val_masked} + {1'b0, lower_ff};
      down_sum   = {1'b0, pos_ff} + {1'b0, val_masked};
      refused    = 1'b0;
      pos_in     = pos_ff;
      unique case (req_cmd)
         pcf_pkg::CMD_A: pos_in = val_masked;
         pcf_pkg::CMD_D: begin
            refused = {1'b0, pos_ff} < up_bound;
            pos_in  = pos_ff - val_masked;
         end
         pcf_pkg::CMD_P: begin
            refused = down_sum > {1'b0, upper_ff};
            pos_in  = down_sum[pcf_pkg::POS_W-1:0];
         end
         default: pos_in = pos_ff;
      endcase
      frame_go = pcf_pkg::cmd_known(req_cmd) && !refused;
      if (!(ctl.load && frame_go)) begin
         pos_in = pos_ff;
      end
   end

   // double dabble, one value bit a cycle
   always_comb begin
      for (int i = 0; i < pcf_pkg::BCD_DIGITS; i++) begin
         bcd_adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ? bcd_ff[4*i +: 4] + 4'd3 :
                                                           bcd_ff[4*i +: 4];
      end
      cmd_in   = cmd_ff;
      addr_in  = addr_ff;
      shift_in = shift_ff;
      bcd_in   = bcd_ff;
      if (ctl.load) begin
         cmd_in   = req_cmd;
         addr_in  = req_pump_address;
         shift_in = val_masked;
         bcd_in   = '0;
      end else if (ctl.conv_step) begin
         shift_in = {shift_ff[pcf_pkg::VAL_W-2:0], 1'b0};
         bcd_in   = {bcd_adj[pcf_pkg::BCD_W-2:0], shift_ff[pcf_pkg::VAL_W-1]};
      end
   end

   // leading digit without zeros in front
   always_comb begin
      priority if (bcd_ff[19:16] != 4'd0) begin
         top_digit = 3'd4;
      end else if (bcd_ff[15:12] != 4'd0) begin
         top_digit = 3'd3;
      end else if (bcd_ff[11:8] != 4'd0) begin
         top_digit = 3'd2;
      end else if (bcd_ff[7:4] != 4'd0) begin
         top_digit = 3'd1;
      end else begin
         top_digit = 3'd0;
      end
   end

   always_comb begin
      sts.frame_go    = frame_go;
      sts.has_value   = pcf_pkg::cmd_has_value(req_cmd);
      sts.value_kind  = pcf_pkg::cmd_has_value(cmd_ff);
      sts.out_free    = !out_valid_ff || rsp_ready;
      sts.letter_last = pcf_pkg::letter_last(cmd_ff);
      sts.top_digit   = top_digit;
   end

   // byte selection, checksum, output register
   always_comb begin
      digit = bcd_ff[4*ctl.idx +: 4];
      unique case (ctl.sel)
         pcf_pkg::SEL_STX:    byte_sel = pcf_pkg::STX_BYTE;
         pcf_pkg::SEL_ADDR:   byte_sel = {4'h0, addr_ff} + pcf_pkg::ADDR_BASE;
         pcf_pkg::SEL_SEQ:    byte_sel = pcf_pkg::SEQ_BYTE;
         pcf_pkg::SEL_LETTER: byte_sel = pcf_pkg::letter_byte(cmd_ff, ctl.idx);
         pcf_pkg::SEL_DIGIT:  byte_sel = pcf_pkg::DIGIT_BASE + {4'h0, digit};
         pcf_pkg::SEL_EXEC:   byte_sel = pcf_pkg::EXEC_BYTE;
         pcf_pkg::SEL_ETX:    byte_sel = pcf_pkg::ETX_BYTE;
         pcf_pkg::SEL_SUM:    byte_sel = sum_ff;
         default:             byte_sel = sum_ff;
      endcase

      sum_in = sum_ff;
      if (ctl.load) begin
         sum_in = '0;
      end else if (ctl.emit) begin
         sum_in = sum_ff ^ byte_sel;
      end

      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (ctl.emit) begin
         out_valid_in = 1'b1;
         out_byte_in  = byte_sel;
         out_last_in  = ctl.last;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_tx_byte   = out_byte_ff;
   assign rsp_last_byte = out_last_ff;

endmodule

`default_nettype wire

// ===== hdl/pump_command_framer.sv =====
// pump_command_framer: top level, joins the sequencer and the datapath
// depends on pcf_pkg, pcf_if, pcf_ctrl and pcf_datapath
//
//   channel  dir  handshake          payload
//   req_bus  in   valid/ready        cmd[3:0], pump_address[3:0], value[15:0]
//   rsp_bus  out  valid/ready        tx_byte[7:0], last_byte
//   csr_*    in   csr_wr_en strobe   csr_index[0], csr_wdata[15:0]
//
// a request is taken from req_bus while idle; kinds with a value then pass through the
// bit-serial binary to decimal converter before the first byte
// frame bytes leave one per cycle from a single output register while rsp_bus is not
// stalled: 7 to 16 bytes; a new request is taken only once the last byte is queued
// refused moves and unknown kinds are taken and send nothing
// a stalled rsp_bus holds the sequencer; synchronous reset clears limits to 0 and
// ffffh and the tracked position to 0
`timescale 1ns / 1ps
`default_nettype none

module pump_command_framer (
   input  wire logic                           clock,
   input  wire logic                           reset,
   pcf_req_if.sink                             req_bus,
   pcf_rsp_if.source                           rsp_bus,
   input  wire logic                           csr_wr_en,
   input  wire logic [pcf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [pcf_pkg::POS_W-1:0]      csr_wdata
);

   pcf_pkg::ctl_type ctl;
   pcf_pkg::sts_type sts;

   pcf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   pcf_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_cmd          (req_bus.cmd),
      .req_pump_address (req_bus.pump_address),
      .req_value        (req_bus.value),
      .rsp_ready        (rsp_bus.ready),
      .rsp_valid        (rsp_bus.valid),
      .rsp_tx_byte      (rsp_bus.tx_byte),
      .rsp_last_byte    (rsp_bus.last_byte),
      .ctl              (ctl),
      .sts              (sts)
   );

endmodule

`default_nettype wire

// ===== hdl/pcf_checker.sv =====
// pcf_checker: port level checks of the pump command framer, bound to the top
// depends on pcf_pkg and pump_command_framer
`timescale 1ns / 1ps
`default_nettype none

module pcf_checker (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   input  wire logic                         req_ready,
   input  wire logic                         rsp_valid,
   input  wire logic                         rsp_ready,
   input  wire logic [pcf_pkg::BYTE_W-1:0]   rsp_tx_byte,
   input  wire logic                         rsp_last_byte
);

   // stalled frame byte holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_tx_byte) && $stable(rsp_last_byte))
      else $error("frame byte changed while stalled");

   // no new request while a frame is still being built
   a_busy_mid_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_byte |-> !req_ready)
      else $error("request taken in the middle of a frame");

   // a request is taken only once the previous frame is fully queued
   a_accept_clean: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !rsp_valid || rsp_last_byte)
      else $error("request taken with frame bytes outstanding");

   // nothing offered right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("frame byte offered after reset");

endmodule

bind pump_command_framer pcf_checker u_pcf_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_tx_byte   (rsp_bus.tx_byte),
   .rsp_last_byte (rsp_bus.last_byte)
);

`default_nettype wire

// ===== dv/pcf_frame_checker.sv =====
// pcf_frame_checker: watches the request, frame byte and limit write ports of the
// pump command framer, predicts every frame byte and compares it in order
// depends on pcf_pkg and the pcf_req_if / pcf_rsp_if interfaces
`timescale 1ns / 1ps

module pcf_frame_checker
   import pcf_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   pcf_req_if                        req_bus,
   pcf_rsp_if                        rsp_bus,
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [POS_W-1:0]     csr_wdata,
   output int                        fail_count,
   output int                        pending_bytes
);

   typedef struct packed {
      logic [BYTE_W-1:0] tx_byte;
      logic              last_byte;
   } frame_byte_type;

   frame_byte_type    frame_bytes_due [$];
   logic [POS_W-1:0]  lower_limit;
   logic [POS_W-1:0]  upper_limit;
   logic [POS_W-1:0]  plunger_pos;

   task automatic queue_frame(input logic [CMD_W-1:0]  cmd,
                              input logic [ADDR_W-1:0] addr,
                              input logic [VAL_W-1:0]  raw);
      logic [BYTE_W-1:0] bytes [$];
      logic [BYTE_W-1:0] digits [$];
      logic [BYTE_W-1:0] sum;
      logic [VAL_W-1:0]  v;
      int                p, d, lo, hi;
      int unsigned       rest;
      bit                with_value;
      frame_byte_type    entry;
      v = raw & VALUE_MASK;
      p = plunger_pos;
      d = v;
      lo = lower_limit;
      hi = upper_limit;
      with_value = 1'b0;
      bytes.push_back(STX_BYTE);
      bytes.push_back(BYTE_W'(ADDR_BASE + addr));
      bytes.push_back(SEQ_BYTE);
      case (cmd)
         CMD_T: bytes.push_back(CH_T);
         CMD_I: bytes.push_back(CH_I);
         CMD_O: bytes.push_back(CH_O);
         CMD_A: begin
            bytes.push_back(CH_A);
            with_value = 1'b1;
            plunger_pos = v;
         end
         CMD_D: begin
            // relative up move, refused below the lower limit
            if (p - d < lo) return;
            bytes.push_back(CH_D);
            with_value = 1'b1;
            plunger_pos = POS_W'(p - d);
         end
         CMD_P: begin
            // relative down move, refused above the upper limit
            if (p + d > hi) return;
            bytes.push_back(CH_P);
            with_value = 1'b1;
            plunger_pos = POS_W'(p + d);
         end
         CMD_Y20: begin
            bytes.push_back(CH_Y);
            bytes.push_back(CH_TWO);
            bytes.push_back(CH_ZERO);
         end
         CMD_S: begin
            bytes.push_back(CH_S);
            with_value = 1'b1;
         end
         CMD_Y20IS: begin
            bytes.push_back(CH_Y);
            bytes.push_back(CH_TWO);
            bytes.push_back(CH_ZERO);
            bytes.push_back(CH_I);
            bytes.push_back(CH_S);
            with_value = 1'b1;
         end
         CMD_Q: bytes.push_back(CH_Q);
         default: return;
      endcase
      if (with_value) begin
         rest = v;
         do begin
            digits.push_front(BYTE_W'(DIGIT_BASE + rest % 10));
            rest = rest / 10;
         end while (rest != 0);
         foreach (digits[k]) bytes.push_back(digits[k]);
      end
      bytes.push_back(EXEC_BYTE);
      bytes.push_back(ETX_BYTE);
      sum = '0;
      foreach (bytes[k]) sum = sum ^ bytes[k];
      bytes.push_back(sum);
      foreach (bytes[k]) begin
         entry.tx_byte   = bytes[k];
         entry.last_byte = (k == bytes.size() - 1);
         frame_bytes_due.push_back(entry);
      end
   endtask

   always @(posedge clock) begin
      frame_byte_type due;
      if (reset) begin
         fail_count  = 0;
         lower_limit = '0;
         upper_limit = '1;
         plunger_pos = '0;
         frame_bytes_due.delete();
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (frame_bytes_due.size() == 0) begin
               fail_count = fail_count + 1;
               $display("%0t: unexpected frame byte: expected none, actual %02h last %0b",
                        $time, rsp_bus.tx_byte, rsp_bus.last_byte);
            end else begin
               due = frame_bytes_due.pop_front();
               if (rsp_bus.tx_byte !== due.tx_byte) begin
                  fail_count = fail_count + 1;
                  $display("%0t: tx_byte mismatch: expected %02h, actual %02h",
                           $time, due.tx_byte, rsp_bus.tx_byte);
               end
               if (rsp_bus.last_byte !== due.last_byte) begin
                  fail_count = fail_count + 1;
                  $display("%0t: last_byte mismatch: expected %0b, actual %0b",
                           $time, due.last_byte, rsp_bus.last_byte);
               end
            end
         end
         // a request taken at this edge cannot have bytes out yet
         if (req_bus.valid && req_bus.ready)
            queue_frame(req_bus.cmd, req_bus.pump_address, req_bus.value);
         if (csr_wr_en) begin
            case (csr_index)
               CSR_LOWER_LIMIT: lower_limit = csr_wdata;
               CSR_UPPER_LIMIT: upper_limit = csr_wdata;
               default: ;
            endcase
         end
      end
      pending_bytes = frame_bytes_due.size();
   end

endmodule

// ===== dv/pump_command_framer_tb.sv =====
// pump_command_framer_tb: drives directed and random pump commands and limit
// settings into the framer, with random stalls on both channels
// depends on pcf_pkg, pcf_if, the framer RTL and pcf_frame_checker
`timescale 1ns / 1ps

module pump_command_framer_tb;
   import pcf_pkg::*;

   localparam int RESET_CYCLES  = 12;
   localparam int SETTLE_CYCLES = 40;
   localparam int LONG_HOLD     = 200;
   localparam int PHASE_ITEMS   = 46;
   localparam int PHASES        = 5;

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [POS_W-1:0]     csr_wdata;
   int                   fail_count;
   int                   pending_bytes;
   bit                   hold_request;
   bit                   quiet;

   pcf_req_if req_bus ();
   pcf_rsp_if rsp_bus ();

   pump_command_framer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   pcf_frame_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .rsp_bus       (rsp_bus),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_bytes (pending_bytes)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("[pump_command_framer] ERROR");
      $finish;
   end

   // receiver: short random stalls, one long hold on request
   initial begin
      rsp_bus.ready = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_bus.ready = 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_request = 1'b0;
            rsp_bus.ready = 1'b1;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_bus.ready = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clock);
            rsp_bus.ready = 1'b1;
         end else begin
            rsp_bus.ready = 1'b1;
         end
      end
   end

   task automatic issue_command(input logic [CMD_W-1:0]  cmd,
                                input logic [ADDR_W-1:0] addr,
                                input logic [VAL_W-1:0]  val);
      @(negedge clock);
      req_bus.valid        = 1'b1;
      req_bus.cmd          = cmd;
      req_bus.pump_address = addr;
      req_bus.value        = val;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic pause_sender(input int cycles);
      @(negedge clock);
      req_bus.valid = 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // drop valid, let every frame byte out, then let the block settle
   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (pending_bytes != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_limit(input logic [CSR_IDX_W-1:0] idx, input logic [POS_W-1:0] data);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic random_command(output logic [CMD_W-1:0]  cmd,
                                 output logic [ADDR_W-1:0] addr,
                                 output logic [VAL_W-1:0]  val);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 4)
         cmd = CMD_W'($urandom_range(int'(CMD_Q) + 1, (1 << CMD_W) - 1));
      else if (pick < 30)
         cmd = CMD_D;
      else if (pick < 55)
         cmd = CMD_P;
      else if (pick < 67)
         cmd = CMD_A;
      else
         cmd = CMD_W'($urandom_range(int'(CMD_T), int'(CMD_Q)));
      addr = ADDR_W'($urandom);
      case ($urandom_range(0, 3))
         0: val = VAL_W'($urandom_range(0, 9));
         1: val = VAL_W'($urandom_range(0, 999));
         2: val = VAL_W'($urandom_range(0, 4000));
         default: val = VAL_W'($urandom);
      endcase
   endtask

   initial begin
      logic [CMD_W-1:0]  cmd;
      logic [ADDR_W-1:0] addr;
      logic [VAL_W-1:0]  val;
      logic [POS_W-1:0]  lo, hi;
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.cmd          = CMD_T;
      req_bus.pump_address = '0;
      req_bus.value        = '0;
      csr_wr_en            = 1'b0;
      csr_index            = CSR_LOWER_LIMIT;
      csr_wdata            = '0;
      hold_request         = 1'b0;
      quiet                = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: every kind, field extremes, both refusals, unknown kinds
      issue_command(CMD_T, 4'd0, 16'd0);
      issue_command(CMD_I, 4'd15, 16'hFFFF);
      issue_command(CMD_O, 4'd5, 16'd0);
      issue_command(CMD_Y20, 4'd3, 16'd7);
      issue_command(CMD_Q, 4'd9, 16'd0);
      issue_command(CMD_S, 4'd1, 16'd0);
      issue_command(CMD_S, 4'd2, 16'hFFFF);
      issue_command(CMD_Y20IS, 4'd15, 16'd12345);
      issue_command(CMD_A, 4'd0, 16'd0);
      issue_command(CMD_A, 4'd4, 16'hFFFF);
      issue_command(CMD_P, 4'd6, 16'd0);
      issue_command(CMD_P, 4'd6, 16'd1);
      issue_command(CMD_D, 4'd7, 16'hFFFF);
      issue_command(CMD_D, 4'd7, 16'd1);
      issue_command(CMD_A, 4'd8, 16'd500);
      issue_command({CMD_W{1'b1}}, 4'd15, 16'hFFFF);
      issue_command(CMD_W'(CMD_Q + 1), 4'd0, 16'd0);
      issue_command(CMD_Y20IS, 4'd10, 16'd9);
      issue_command(CMD_P, 4'd11, 16'd65035);
      issue_command(CMD_D, 4'd12, 16'hFFFF);
      issue_command(CMD_S, 4'd13, 16'd10000);
      wait_drained();

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin lo = 16'd100;  hi = 16'd4000;  end
            1: begin lo = 16'd0;    hi = 16'd0;     end
            2: begin lo = 16'hFFFF; hi = 16'hFFFF;  end
            3: begin
               lo = POS_W'($urandom_range(0, 3000));
               hi = POS_W'(lo + $urandom_range(0, 3000));
            end
            default: begin lo = 16'd0; hi = 16'hFFFF; end
         endcase
         write_limit(CSR_LOWER_LIMIT, lo);
         write_limit(CSR_UPPER_LIMIT, hi);
         quiet = (ph == PHASES - 1);
         if (ph == 0) begin
            // long receiver hold while requests keep coming
            hold_request = 1'b1;
            for (int i = 0; i < 20; i++) begin
               random_command(cmd, addr, val);
               issue_command(cmd, addr, val);
            end
         end
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            random_command(cmd, addr, val);
            issue_command(cmd, addr, val);
            if (!quiet && (i % 24) < 16 && $urandom_range(0, 3) == 0)
               pause_sender($urandom_range(1, 15));
         end
         wait_drained();
      end

      if (fail_count == 0 && pending_bytes == 0) begin
         $display("[pump_command_framer] OK");
      end else begin
         $display("[pump_command_framer] ERROR");
      end
      $finish;
   end

endmodule
